/* hw/rtl/klsm_pkg.sv */
// ----------------------------------------------------------------------------
// klsm_pkg: shared types and constants for the key lifecycle state machine
// Request structs, action and state codes, and the per-algorithm tables.
// ----------------------------------------------------------------------------
`default_nettype none

package klsm_pkg;

    // Action codes carried in a request.
    localparam logic [2:0] ACT_INIT       = 3'd0;
    localparam logic [2:0] ACT_ACTIVATE   = 3'd1;
    localparam logic [2:0] ACT_DEACTIVATE = 3'd2;
    localparam logic [2:0] ACT_REVOKE     = 3'd3;
    localparam logic [2:0] ACT_DESTROY    = 3'd4;
    localparam logic [2:0] ACT_ARCHIVE    = 3'd5;
    localparam logic [2:0] ACT_QUERY      = 3'd6;

    // Slot state codes.
    localparam logic [2:0] ST_EMPTY       = 3'd0;
    localparam logic [2:0] ST_PREACTIVE   = 3'd1;
    localparam logic [2:0] ST_ACTIVE      = 3'd2;
    localparam logic [2:0] ST_DEACTIVATED = 3'd3;
    localparam logic [2:0] ST_COMPROMISED = 3'd4;
    localparam logic [2:0] ST_ARCHIVED    = 3'd5;
    localparam logic [2:0] ST_DESTROYED   = 3'd6;

    // Algorithm codes.
    localparam logic [2:0] ALG_RSA2048 = 3'd0;
    localparam logic [2:0] ALG_RSA4096 = 3'd1;
    localparam logic [2:0] ALG_P256    = 3'd2;
    localparam logic [2:0] ALG_P384    = 3'd3;

    localparam int DELTA_W = 33;
    localparam logic [16:0] SECONDS_PER_DAY = 17'd86400;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] now_seconds;
        logic [2:0]  algorithm;
        logic [15:0] valid_days;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  key_state;
        logic        usable;
        logic [9:0]  key_bytes;
        logic [63:0] expiry_out;
    } t_out_item;

    // A registered request together with its precomputed time offset.
    typedef struct packed {
        t_in_item             item;
        logic [DELTA_W-1:0]   delta;
    } t_stage;

    // Key lifetime in seconds for each algorithm, used by init.
    function automatic logic [DELTA_W-1:0] lifetime_secs(input logic [2:0] alg);
        logic [DELTA_W-1:0] secs;
        case (alg)
            ALG_RSA2048: secs = DELTA_W'(64'd730 * 64'd86400);
            ALG_RSA4096: secs = DELTA_W'(64'd1825 * 64'd86400);
            ALG_P256:    secs = DELTA_W'(64'd1095 * 64'd86400);
            ALG_P384:    secs = DELTA_W'(64'd1825 * 64'd86400);
            default:     secs = DELTA_W'(64'd365 * 64'd86400);
        endcase
        return secs;
    endfunction

    // Key material length in bytes for each algorithm, used by activate.
    function automatic logic [9:0] material_for(input logic [2:0] alg);
        logic [9:0] len;
        case (alg)
            ALG_RSA2048: len = 10'd256;
            ALG_RSA4096: len = 10'd512;
            ALG_P256:    len = 10'd32;
            ALG_P384:    len = 10'd48;
            default:     len = 10'd32;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/key_lifecycle_state_machine.sv */
// ----------------------------------------------------------------------------
// key_lifecycle_state_machine: one key slot with a lifecycle state machine
// Takes lifecycle requests and returns one result for each of them.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// request   in         i_valid / o_stall   i_item  (klsm_pkg::t_in_item)
// result    out        o_valid / i_stall   o_item  (klsm_pkg::t_out_item)
//
// A request passes from acceptance to its result through the request register,
// where the time offset is multiplied out, and then through the slot update
// into the result register. One request is accepted every cycle while o_stall is low.
// Reset clears the slot to empty with all fields zero; no items are pending.
// A stalled result holds; the request side stalls only when both registers are full and i_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

module key_lifecycle_state_machine (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire klsm_pkg::t_in_item  i_item,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output klsm_pkg::t_out_item      o_item
);

    logic             w_stage_valid;
    logic             w_hold;
    klsm_pkg::t_stage w_stage;

    // Request register with offset precompute.
    klsm_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .i_hold  (w_hold),
        .o_valid (w_stage_valid),
        .o_stage (w_stage)
    );

    // Slot update and result register.
    klsm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_stage_valid),
        .i_stage (w_stage),
        .o_hold  (w_hold),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire

/* hw/rtl/klsm_decode.sv */
// ----------------------------------------------------------------------------
// klsm_decode: request register of the key lifecycle state machine
// Captures one request and precomputes the seconds to add to the current time.
// ----------------------------------------------------------------------------
`default_nettype none

module klsm_decode (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire klsm_pkg::t_in_item i_item,
    input  wire logic              i_hold,
    output logic                   o_valid,
    output klsm_pkg::t_stage       o_stage
);

    logic                 r_valid;
    logic                 n_valid;
    klsm_pkg::t_stage     r_stage;
    logic                 w_load;
    logic [klsm_pkg::DELTA_W-1:0] w_days_secs;

    // The register is blocked only when it is full and the core cannot take it.
    assign o_stall = r_valid & i_hold;
    assign w_load  = i_valid & ~o_stall;

    // Validity days times one day, a 16 by 17 bit constant multiply.
    assign w_days_secs = klsm_pkg::DELTA_W'(i_item.valid_days)
                       * klsm_pkg::DELTA_W'(klsm_pkg::SECONDS_PER_DAY);

    always_comb begin
        if (w_load) begin
            n_valid = 1'b1;
        end else if (~i_hold) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload register; the offset is chosen by the action.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_stage.item <= i_item;
            if (i_item.action == klsm_pkg::ACT_INIT) begin
                r_stage.delta <= klsm_pkg::lifetime_secs(i_item.algorithm);
            end else begin
                r_stage.delta <= w_days_secs;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

`default_nettype wire

/* hw/rtl/klsm_core.sv */
// ----------------------------------------------------------------------------
// klsm_core: slot state and result register of the key lifecycle state machine
// Applies one request per cycle to the key slot while o_hold is low, and registers its result.
// ----------------------------------------------------------------------------
`default_nettype none

module klsm_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire klsm_pkg::t_stage   i_stage,
    output logic                    o_hold,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output klsm_pkg::t_out_item     o_item
);

    logic [2:0]  r_state;
    logic [2:0]  n_state;
    logic [2:0]  r_algo;
    logic [2:0]  n_algo;
    logic [63:0] r_act_time;
    logic [63:0] n_act_time;
    logic [63:0] r_expiry;
    logic [63:0] n_expiry;
    logic [9:0]  r_mat_len;
    logic [9:0]  n_mat_len;
    logic        r_out_valid;
    logic        n_out_valid;
    klsm_pkg::t_out_item r_out;

    logic        w_take;
    logic        w_acc;
    logic        w_use;
    logic [63:0] w_now;
    logic [63:0] w_sum;

    // A request moves on when the result register is empty or being drained.
    assign o_hold = r_out_valid & i_stall;
    assign w_take = i_valid & ~o_hold;

    assign w_now = i_stage.item.now_seconds;
    assign w_sum = w_now + 64'(i_stage.delta);

    // Transition of the slot for the current request.
    always_comb begin
        n_state    = r_state;
        n_algo     = r_algo;
        n_act_time = r_act_time;
        n_expiry   = r_expiry;
        n_mat_len  = r_mat_len;
        w_acc      = 1'b0;
        case (i_stage.item.action)
            klsm_pkg::ACT_INIT: begin
                n_algo     = i_stage.item.algorithm;
                n_act_time = 64'd0;
                n_mat_len  = 10'd0;
                n_expiry   = w_sum;
                n_state    = klsm_pkg::ST_PREACTIVE;
                w_acc      = 1'b1;
            end
            klsm_pkg::ACT_ACTIVATE: begin
                if (r_state == klsm_pkg::ST_PREACTIVE) begin
                    if (r_mat_len == 10'd0) begin
                        n_mat_len = klsm_pkg::material_for(r_algo);
                    end
                    n_state    = klsm_pkg::ST_ACTIVE;
                    n_act_time = w_now;
                    if (i_stage.item.valid_days != 16'd0) begin
                        n_expiry = w_sum;
                    end
                    w_acc = 1'b1;
                end
            end
            klsm_pkg::ACT_DEACTIVATE: begin
                if (r_state == klsm_pkg::ST_ACTIVE) begin
                    n_state = klsm_pkg::ST_DEACTIVATED;
                    w_acc   = 1'b1;
                end
            end
            klsm_pkg::ACT_REVOKE: begin
                n_state   = klsm_pkg::ST_COMPROMISED;
                n_mat_len = 10'd0;
                w_acc     = 1'b1;
            end
            klsm_pkg::ACT_DESTROY: begin
                if (r_state != klsm_pkg::ST_DESTROYED) begin
                    n_algo     = 3'd0;
                    n_act_time = 64'd0;
                    n_expiry   = 64'd0;
                    n_mat_len  = 10'd0;
                    n_state    = klsm_pkg::ST_DESTROYED;
                    w_acc      = 1'b1;
                end
            end
            klsm_pkg::ACT_ARCHIVE: begin
                if (r_state == klsm_pkg::ST_DEACTIVATED) begin
                    n_state = klsm_pkg::ST_ARCHIVED;
                    w_acc   = 1'b1;
                end
            end
            default: begin
                w_acc = 1'b0;
            end
        endcase
    end

    // Usability is judged on the state after the request.
    assign w_use = (n_state == klsm_pkg::ST_ACTIVE) && (w_now >= n_act_time)
                   && (w_now < n_expiry);

    always_comb begin
        if (w_take) begin
            n_out_valid = 1'b1;
        end else if (~i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Slot state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= klsm_pkg::ST_EMPTY;
            r_algo      <= 3'd0;
            r_act_time  <= 64'd0;
            r_expiry    <= 64'd0;
            r_mat_len   <= 10'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_take) begin
                r_state    <= n_state;
                r_algo     <= n_algo;
                r_act_time <= n_act_time;
                r_expiry   <= n_expiry;
                r_mat_len  <= n_mat_len;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out.accepted   <= (i_stage.item.action == klsm_pkg::ACT_QUERY) ? w_use : w_acc;
            r_out.key_state  <= n_state;
            r_out.usable     <= w_use;
            r_out.key_bytes  <= n_mat_len;
            r_out.expiry_out <= n_expiry;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // A usable key is always active and always holds key material.
    a_usable_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.usable) |->
            (r_out.key_state == klsm_pkg::ST_ACTIVE && r_out.key_bytes != 10'd0))
        else $error("usable result without an active key");

    // A destroyed slot keeps no expiry and no material.
    a_destroyed_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == klsm_pkg::ST_DESTROYED) |-> (r_expiry == 64'd0 && r_mat_len == 10'd0))
        else $error("destroyed slot still holds data");

    // A query never moves the slot.
    a_query_static: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_stage.item.action == klsm_pkg::ACT_QUERY) |=>
            (r_state == $past(r_state) && r_expiry == $past(r_expiry)))
        else $error("query changed the slot");

    // The slot only changes when a request is taken.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_take |=> $stable(r_state))
        else $error("slot state changed without a request");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for key_lifecycle_state_machine
// Drives lifecycle requests through the valid/stall request channel and
// predicts each result with a cycle-free model of the key slot. Every result
// is compared field by field with the oldest prediction still due. Directed
// tests cover the empty slot, a full lifecycle, the usable window and expiry
// wrap. A long random phase then walks mostly legal lifecycles with noise.
// Both sides insert random gaps, with stretches that run back to back.
// ----------------------------------------------------------------------------
module tb_top;
    import klsm_pkg::*;

    // The action code that the block must ignore.
    localparam logic [2:0]  ACT_UNDEFINED = 3'd7;
    localparam logic [2:0]  ALG_OTHER     = 3'd4;
    localparam logic [63:0] SECS_PER_DAY  = 64'd86400;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    key_lifecycle_state_machine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    // Predicted copy of the key slot.
    logic [2:0]  key_state_q;
    logic [2:0]  key_algo_q;
    logic [63:0] key_act_time_q;
    logic [63:0] key_expiry_q;
    logic [9:0]  key_len_q;

    // Results predicted but not yet seen, oldest first.
    t_out_item   due_results[$];

    logic        src_idle_on;
    logic        sink_idle_on;
    logic [63:0] wall_clock;
    int          fail_count;
    int          requests_sent;
    int          results_checked;
    int          accepted_seen;
    int          usable_seen;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest legal run.
    initial begin : watchdog
        #5000000;
        $display("Timeout with %0d results still due", due_results.size());
        $display("Test completed with failures");
        $finish;
    end

    // Key lifetime in seconds, chosen by the algorithm at init.
    function automatic logic [63:0] key_lifetime_secs(input logic [2:0] alg);
        case (alg)
            ALG_RSA2048: return 64'd730 * SECS_PER_DAY;
            ALG_RSA4096: return 64'd1825 * SECS_PER_DAY;
            ALG_P256:    return 64'd1095 * SECS_PER_DAY;
            ALG_P384:    return 64'd1825 * SECS_PER_DAY;
            default:     return 64'd365 * SECS_PER_DAY;
        endcase
    endfunction

    // Key length in bytes, given at activation when none is held.
    function automatic logic [9:0] key_material_bytes(input logic [2:0] alg);
        case (alg)
            ALG_RSA2048: return 10'd256;
            ALG_RSA4096: return 10'd512;
            ALG_P256:    return 10'd32;
            ALG_P384:    return 10'd48;
            default:     return 10'd32;
        endcase
    endfunction

    function automatic logic key_usable_at(input logic [63:0] now_s);
        return key_state_q == ST_ACTIVE && now_s >= key_act_time_q && now_s < key_expiry_q;
    endfunction

    // Apply one request to the predicted slot and return the result it gives.
    function automatic t_out_item apply_lifecycle_action(input t_in_item req);
        t_out_item res;
        logic      ok;
        ok = 1'b0;
        case (req.action)
            ACT_INIT: begin
                key_state_q    = ST_PREACTIVE;
                key_algo_q     = req.algorithm;
                key_act_time_q = '0;
                key_len_q      = '0;
                key_expiry_q   = req.now_seconds + key_lifetime_secs(req.algorithm);
                ok = 1'b1;
            end
            ACT_ACTIVATE: begin
                if (key_state_q == ST_PREACTIVE) begin
                    if (key_len_q == '0) begin
                        key_len_q = key_material_bytes(key_algo_q);
                    end
                    key_state_q    = ST_ACTIVE;
                    key_act_time_q = req.now_seconds;
                    if (req.valid_days != '0) begin
                        key_expiry_q = req.now_seconds
                                     + 64'(req.valid_days) * SECS_PER_DAY;
                    end
                    ok = 1'b1;
                end
            end
            ACT_DEACTIVATE: begin
                if (key_state_q == ST_ACTIVE) begin
                    key_state_q = ST_DEACTIVATED;
                    ok = 1'b1;
                end
            end
            ACT_REVOKE: begin
                key_state_q = ST_COMPROMISED;
                key_len_q   = '0;
                ok = 1'b1;
            end
            ACT_DESTROY: begin
                if (key_state_q != ST_DESTROYED) begin
                    key_state_q    = ST_DESTROYED;
                    key_algo_q     = '0;
                    key_act_time_q = '0;
                    key_expiry_q   = '0;
                    key_len_q      = '0;
                    ok = 1'b1;
                end
            end
            ACT_ARCHIVE: begin
                if (key_state_q == ST_DEACTIVATED) begin
                    key_state_q = ST_ARCHIVED;
                    ok = 1'b1;
                end
            end
            ACT_QUERY: begin
                ok = key_usable_at(req.now_seconds);
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        res.accepted   = ok;
        res.key_state  = key_state_q;
        res.usable     = key_usable_at(req.now_seconds);
        res.key_bytes  = key_len_q;
        res.expiry_out = key_expiry_q;
        return res;
    endfunction

    // Print one line per mismatch and count every one.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH result %0d %s: got %0h, expected %0h",
                 results_checked, what, got, want);
        fail_count++;
    endtask

    // Compare one accepted result with the oldest prediction.
    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (due_results.size() == 0) begin
            report_mismatch("result with nothing due", 64'(got), 64'd0);
        end else begin
            want = due_results.pop_front();
            if (got.accepted !== want.accepted)
                report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
            if (got.key_state !== want.key_state)
                report_mismatch("key_state", 64'(got.key_state), 64'(want.key_state));
            if (got.usable !== want.usable)
                report_mismatch("usable", 64'(got.usable), 64'(want.usable));
            if (got.key_bytes !== want.key_bytes)
                report_mismatch("key_bytes", 64'(got.key_bytes), 64'(want.key_bytes));
            if (got.expiry_out !== want.expiry_out)
                report_mismatch("expiry_out", got.expiry_out, want.expiry_out);
            accepted_seen += want.accepted;
            usable_seen   += want.usable;
        end
        results_checked++;
    endtask

    // Send one request; called and returns at a falling edge.
    task automatic send_request(input logic [2:0] action, input logic [63:0] now_s,
                                input logic [2:0] alg, input logic [15:0] days);
        t_in_item req;
        int       gap;
        req.action        = action;
        req.now_seconds   = now_s;
        req.algorithm     = alg;
        req.valid_days    = days;
        gap = src_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= req;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        due_results.push_back(apply_lifecycle_action(req));
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Result side: random stall before each result, then take it.
    initial begin : result_sink
        int hold;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            hold = sink_idle_on ? $urandom_range(0, 7) : 0;
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_valid !== 1'b1);
            check_result(o_item);
            @(negedge i_clk);
        end
    end

    // Requests against an empty slot, including the undefined action code.
    task automatic test_empty_slot();
        send_request(ACT_QUERY, 64'd0, ALG_RSA2048, 16'd0);
        send_request(ACT_UNDEFINED, '1, '1, '1);
        send_request(ACT_ACTIVATE, 64'd5, ALG_P256, 16'd10);
        send_request(ACT_DEACTIVATE, 64'd6, ALG_RSA2048, 16'd0);
        send_request(ACT_ARCHIVE, 64'd7, ALG_RSA2048, 16'd0);
    endtask

    // One key through every legal step, with the illegal repeats rejected.
    task automatic test_full_lifecycle();
        send_request(ACT_INIT, 64'd1000, ALG_RSA4096, 16'd0);
        send_request(ACT_ACTIVATE, 64'd2000, ALG_RSA2048, 16'd0);
        send_request(ACT_QUERY, 64'd2000, ALG_RSA2048, 16'd0);
        send_request(ACT_DEACTIVATE, 64'd2100, ALG_RSA2048, 16'd0);
        send_request(ACT_DEACTIVATE, 64'd2200, ALG_RSA2048, 16'd0);
        send_request(ACT_ARCHIVE, 64'd2300, ALG_RSA2048, 16'd0);
        send_request(ACT_ARCHIVE, 64'd2400, ALG_RSA2048, 16'd0);
        send_request(ACT_DESTROY, 64'd2500, ALG_RSA2048, 16'd0);
        send_request(ACT_DESTROY, 64'd2600, ALG_RSA2048, 16'd0);
    endtask

    // Edges of the usable window with the longest validity override.
    task automatic test_expiry_window();
        logic [63:0] expiry;
        expiry = 64'd20 + 64'd65535 * SECS_PER_DAY;
        send_request(ACT_INIT, 64'd10, ALG_P256, 16'd0);
        send_request(ACT_ACTIVATE, 64'd20, ALG_RSA2048, 16'hFFFF);
        send_request(ACT_QUERY, 64'd19, ALG_RSA2048, 16'd0);
        send_request(ACT_QUERY, expiry - 64'd1, ALG_RSA2048, 16'd0);
        send_request(ACT_QUERY, expiry, ALG_RSA2048, 16'd0);
        send_request(ACT_REVOKE, expiry, ALG_RSA2048, 16'd0);
        send_request(ACT_ACTIVATE, expiry, ALG_RSA2048, 16'd0);
    endtask

    // Expiry sums that wrap, unknown algorithm codes, revoke from pre-active.
    task automatic test_wrap_and_revoke();
        send_request(ACT_INIT, '1, 3'd7, 16'd0);
        send_request(ACT_ACTIVATE, '1 - 64'd100, ALG_RSA2048, 16'd1);
        send_request(ACT_QUERY, '1 - 64'd100, ALG_RSA2048, 16'd0);
        send_request(ACT_INIT, 64'd0, ALG_P384, 16'd0);
        send_request(ACT_REVOKE, 64'd1, ALG_RSA2048, 16'd0);
        send_request(ACT_INIT, 64'd2, ALG_OTHER, 16'd0);
        send_request(ACT_DESTROY, 64'd3, ALG_RSA2048, 16'd0);
    endtask

    // Mostly the next legal step for the predicted state, some pure noise.
    function automatic logic [2:0] next_lifecycle_action();
        int r;
        r = $urandom_range(0, 5);
        if ($urandom_range(0, 9) < 3) begin
            return 3'($urandom_range(0, 7));
        end
        case (key_state_q)
            ST_PREACTIVE:   return (r == 0) ? ACT_REVOKE : ACT_ACTIVATE;
            ST_ACTIVE: begin
                if (r < 3) return ACT_QUERY;
                if (r == 3) return ACT_DEACTIVATE;
                return (r == 4) ? ACT_REVOKE : ACT_DESTROY;
            end
            ST_DEACTIVATED: return (r < 4) ? ACT_ARCHIVE : ACT_QUERY;
            ST_COMPROMISED: return (r < 3) ? ACT_DESTROY : ACT_INIT;
            ST_ARCHIVED:    return (r < 4) ? ACT_DESTROY : ACT_QUERY;
            default:        return ACT_INIT;
        endcase
    endfunction

    // Times cluster around the edges of the usable window.
    function automatic logic [63:0] pick_time();
        case ($urandom_range(0, 11))
            0: begin
                wall_clock = {$urandom, $urandom};
                return wall_clock;
            end
            1: return key_expiry_q - 64'd1;
            2: return key_expiry_q;
            3: return key_act_time_q;
            4: return key_act_time_q - 64'd1;
            default: begin
                wall_clock = wall_clock + 64'($urandom_range(0, 2000000));
                return wall_clock;
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_days();
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'($urandom);
            default: return 16'($urandom_range(1, 400));
        endcase
    endfunction

    // Random lifecycles, changing the idle pattern every hundred requests.
    task automatic test_random_lifecycles(input int count);
        logic [1:0] mode;
        for (int k = 0; k < count; k++) begin
            if (k % 100 == 0) begin
                mode = 2'($urandom_range(0, 3));
                src_idle_on  = ~mode[0];
                sink_idle_on = ~mode[1];
            end
            send_request(next_lifecycle_action(), pick_time(),
                         3'($urandom_range(0, 7)), pick_days());
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // Main sequence.
    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_item          = '0;
        src_idle_on     = 1'b1;
        sink_idle_on    = 1'b1;
        wall_clock      = 64'd100000;
        fail_count      = 0;
        requests_sent   = 0;
        results_checked = 0;
        accepted_seen   = 0;
        usable_seen     = 0;
        key_state_q     = ST_EMPTY;
        key_algo_q      = '0;
        key_act_time_q  = '0;
        key_expiry_q    = '0;
        key_len_q       = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_slot();
        test_full_lifecycle();
        test_expiry_window();
        test_wrap_and_revoke();
        test_random_lifecycles(1500);

        i_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d lifecycle requests and checked %0d results.",
                 requests_sent, results_checked);
        $display("Predicted %0d accepted actions and %0d usable-key results.",
                 accepted_seen, usable_seen);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* key_lifecycle_state_machine.f */
hw/rtl/klsm_pkg.sv
hw/rtl/klsm_decode.sv
hw/rtl/klsm_core.sv
hw/rtl/key_lifecycle_state_machine.sv
dv/tb_top.sv
